/* hw/rtl/irpw_pkg.sv */
// ----------------------------------------------------------------------------
// irpw_pkg
// Shared types, constants and the remote key table for the IR pulse width
// decoder.
// ----------------------------------------------------------------------------
package irpw_pkg;

	// Default sizes
	localparam int MAX_PAIRS_DEF = 200;
	localparam int CODE_BITS_DEF = 32;

	// Field widths
	localparam int TICK_W  = 14;
	localparam int PAIR_W  = 8;
	localparam int OCODE_W = 32;
	localparam int KEY_W   = 5;
	localparam int REG_W   = 32;
	localparam int IDX_W   = 3;

	localparam logic [TICK_W-1:0] RUN_MAX = 14'h3fff;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_BIT_THRESHOLD = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAP_LIMIT     = 3'd1;
	localparam logic [IDX_W-1:0] REG_RED_CODE      = 3'd2;
	localparam logic [IDX_W-1:0] REG_GREEN_CODE    = 3'd3;
	localparam logic [IDX_W-1:0] REG_BLUE_CODE     = 3'd4;

	// Register reset values
	localparam logic [TICK_W-1:0]  BIT_THRESHOLD_RST = 14'd500;
	localparam logic [TICK_W-1:0]  GAP_LIMIT_RST     = 14'd10000;
	localparam logic [OCODE_W-1:0] RED_CODE_RST      = 32'hc03fcc33;
	localparam logic [OCODE_W-1:0] GREEN_CODE_RST    = 32'hc03fc639;
	localparam logic [OCODE_W-1:0] BLUE_CODE_RST     = 32'hc03fdea1;

	// Key table
	localparam int KEY_COUNT = 21;
	localparam logic [KEY_W-1:0] KEY_UNKNOWN = 5'd21;

	typedef logic [OCODE_W-1:0] key_table_t [KEY_COUNT];
	localparam key_table_t KEY_TABLE = '{
		32'hc03fe897, 32'hc03fcc33, 32'hc03fd8a7, 32'hc03ff887, 32'hc03fc8b7,
		32'hc03fc0bf, 32'hc03ff08f, 32'hc03ff807, 32'hc03fea15, 32'hc03fe41b,
		32'hc03fda25, 32'hc03fc639, 32'hc03fdea1, 32'hc03fc43b, 32'hc03fce31,
		32'hc03fd6a9, 32'hc03fd0af, 32'hc03fd2ad, 32'hc03fd4ab, 32'hc03fe619,
		32'hc03fec13
	};

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One finished frame
	typedef struct packed {
		logic [OCODE_W-1:0] code;
		logic [PAIR_W-1:0]  pairs;
	} frame_t;

	// Queue status
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// LED match codes
	typedef struct packed {
		logic [OCODE_W-1:0] red;
		logic [OCODE_W-1:0] green;
		logic [OCODE_W-1:0] blue;
	} led_codes_t;

	// Result beat
	typedef struct packed {
		logic               blue_on;
		logic               green_on;
		logic               red_on;
		logic [PAIR_W-1:0]  pair_count;
		logic [KEY_W-1:0]   key_index;
		logic [OCODE_W-1:0] ir_code;
	} result_t;

	// First matching key wins; unknown when none matches
	function automatic logic [KEY_W-1:0] key_lookup(input logic [OCODE_W-1:0] code);
		logic [KEY_W-1:0] key;
		key = KEY_UNKNOWN;
		for (int k = KEY_COUNT - 1; k >= 0; k--) begin
			if (KEY_TABLE[k] == code)
				key = KEY_W'(k);
		end
		return key;
	endfunction

endpackage

/* hw/rtl/irpw_front.sv */
// ----------------------------------------------------------------------------
// irpw_front
// Times high and low runs per sample tick, collects code bits and hands each
// finished frame to the queue.
// ----------------------------------------------------------------------------
module irpw_front #(
	parameter int MAX_PAIRS = irpw_pkg::MAX_PAIRS_DEF,
	parameter int CODE_BITS = irpw_pkg::CODE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        level,
	input  logic [irpw_pkg::TICK_W-1:0] bit_threshold,
	input  logic [irpw_pkg::TICK_W-1:0] gap_limit,
	input  irpw_pkg::queue_stat_t       qstat,
	output logic                        push,
	output irpw_pkg::frame_t            push_frame
);

	localparam int POS_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

	logic                        phase_q;
	logic [irpw_pkg::TICK_W-1:0] run_q;
	logic [irpw_pkg::PAIR_W-1:0] pair_q;
	logic [CODE_BITS-1:0]        code_q;

	logic                        accept;
	logic                        phase_n;
	logic [irpw_pkg::TICK_W-1:0] run_n;
	logic [irpw_pkg::PAIR_W-1:0] pair_n;
	logic [CODE_BITS-1:0]        code_n;
	logic [POS_W-1:0]            pos;
	logic                        bit_val;
	logic                        done;

	// stall only when the queue has no room
	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	// next state for one sample
	always_comb begin
		phase_n = phase_q;
		run_n   = run_q;
		pair_n  = pair_q;
		code_n  = code_q;
		pos     = POS_W'(CODE_BITS - 1) - pair_q[POS_W-1:0];
		bit_val = !(run_q != '0 && run_q < bit_threshold);
		if (!phase_q && !level) begin
			// high run ends: store its bit
			if (pair_q < irpw_pkg::PAIR_W'(CODE_BITS))
				code_n[pos] = bit_val;
			phase_n = 1'b1;
			run_n   = '0;
		end else if (phase_q && level) begin
			// low run ends: pair complete
			pair_n  = pair_q + 1'b1;
			phase_n = 1'b0;
			run_n   = '0;
		end
		if (run_n != irpw_pkg::RUN_MAX)
			run_n = run_n + 1'b1;
		done = (run_n >= gap_limit && pair_n != '0)
			|| pair_n == irpw_pkg::PAIR_W'(MAX_PAIRS);
	end

	assign push             = accept && done;
	assign push_frame.code  = irpw_pkg::OCODE_W'(code_n);
	assign push_frame.pairs = pair_n;

	// run timing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			run_q   <= '0;
			pair_q  <= '0;
			code_q  <= '0;
		end else if (accept) begin
			code_q <= code_n;
			if (done) begin
				phase_q <= 1'b0;
				run_q   <= '0;
				pair_q  <= '0;
			end else begin
				phase_q <= phase_n;
				run_q   <= run_n;
				pair_q  <= pair_n;
			end
		end
	end

endmodule

/* hw/rtl/irpw_queue.sv */
// ----------------------------------------------------------------------------
// irpw_queue
// Short first-in first-out queue of finished frames between front and back.
// ----------------------------------------------------------------------------
module irpw_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  irpw_pkg::frame_t      push_frame,
	input  logic                  pop,
	output irpw_pkg::frame_t      pop_frame,
	output irpw_pkg::queue_stat_t qstat
);

	irpw_pkg::frame_t              mem_q [irpw_pkg::QUEUE_DEPTH];
	logic [irpw_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [irpw_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [irpw_pkg::QPTR_W:0]     count_q;

	assign qstat.full  = count_q == (irpw_pkg::QPTR_W+1)'(irpw_pkg::QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign pop_frame   = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_frame;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* hw/rtl/irpw_back.sv */
// ----------------------------------------------------------------------------
// irpw_back
// Looks up the key, toggles the LEDs and holds the result beat until taken.
// ----------------------------------------------------------------------------
module irpw_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  irpw_pkg::queue_stat_t qstat,
	input  irpw_pkg::frame_t      frame,
	output logic                  pop,
	input  irpw_pkg::led_codes_t  codes,
	output logic                  out_valid,
	input  logic                  out_ready,
	output irpw_pkg::result_t     result
);

	logic [2:0]        led_q;
	logic [2:0]        led_n;
	logic              valid_q;
	irpw_pkg::result_t result_q;

	// take a frame when the output register is free or being emptied
	assign pop = !qstat.empty && (!valid_q || out_ready);

	// first matching LED register toggles
	always_comb begin
		led_n = led_q;
		if (frame.code == codes.red)
			led_n[0] = !led_q[0];
		else if (frame.code == codes.green)
			led_n[1] = !led_q[1];
		else if (frame.code == codes.blue)
			led_n[2] = !led_q[2];
	end

	// control and LED state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			led_q   <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				led_q   <= led_n;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.ir_code    <= frame.code;
			result_q.key_index  <= irpw_pkg::key_lookup(frame.code);
			result_q.pair_count <= frame.pairs;
			result_q.red_on     <= led_n[0];
			result_q.green_on   <= led_n[1];
			result_q.blue_on    <= led_n[2];
		end
	end

	assign out_valid = valid_q;
	assign result    = result_q;

endmodule

/* hw/rtl/ir_pulse_width_decoder_unit.sv */
// ----------------------------------------------------------------------------
// ir_pulse_width_decoder_unit
// IR remote pulse width decoder: one pin sample per beat in, one result
// beat per finished frame out.
// ----------------------------------------------------------------------------
// Throughput: one sample beat per clock; the front run timer takes a sample
// every cycle while the frame queue has room.
// Path: the result of the sample that ends a frame reaches m_tdata through
// the queue write, then the back output register.
// Reset: arst_n clears run timer, pair count, code bits, LEDs and queue, and
// loads the register defaults; no clearing pass.
module ir_pulse_width_decoder_unit #(
	parameter int MAX_PAIRS = irpw_pkg::MAX_PAIRS_DEF,
	parameter int CODE_BITS = irpw_pkg::CODE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] ir_level, [7:1] zero
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] ir_code, [36:32] key_index,
	                               // [44:37] pair_count, [45] red_on,
	                               // [46] green_on, [47] blue_on
	// register writes
	input  logic                          wr_en,
	input  logic [irpw_pkg::IDX_W-1:0]    wr_index,
	input  logic [irpw_pkg::REG_W-1:0]    wr_data
);

	logic [irpw_pkg::TICK_W-1:0] thr_q;
	logic [irpw_pkg::TICK_W-1:0] gap_q;
	irpw_pkg::led_codes_t        codes_q;

	logic                  push;
	logic                  pop;
	irpw_pkg::frame_t      push_frame;
	irpw_pkg::frame_t      pop_frame;
	irpw_pkg::queue_stat_t qstat;
	irpw_pkg::result_t     result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= irpw_pkg::BIT_THRESHOLD_RST;
			gap_q         <= irpw_pkg::GAP_LIMIT_RST;
			codes_q.red   <= irpw_pkg::RED_CODE_RST;
			codes_q.green <= irpw_pkg::GREEN_CODE_RST;
			codes_q.blue  <= irpw_pkg::BLUE_CODE_RST;
		end else if (wr_en) begin
			case (wr_index)
				irpw_pkg::REG_BIT_THRESHOLD: thr_q <= wr_data[irpw_pkg::TICK_W-1:0];
				irpw_pkg::REG_GAP_LIMIT:     gap_q <= wr_data[irpw_pkg::TICK_W-1:0];
				irpw_pkg::REG_RED_CODE:      codes_q.red <= wr_data;
				irpw_pkg::REG_GREEN_CODE:    codes_q.green <= wr_data;
				irpw_pkg::REG_BLUE_CODE:     codes_q.blue <= wr_data;
				default: ;
			endcase
		end
	end

	irpw_front #(
		.MAX_PAIRS (MAX_PAIRS),
		.CODE_BITS (CODE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.level         (s_tdata[0]),
		.bit_threshold (thr_q),
		.gap_limit     (gap_q),
		.qstat         (qstat),
		.push          (push),
		.push_frame    (push_frame)
	);

	irpw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.pop_frame  (pop_frame),
		.qstat      (qstat)
	);

	irpw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.frame     (pop_frame),
		.pop       (pop),
		.codes     (codes_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result)
	);

	assign m_tdata = result;

	// no frame is written into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) qstat.full |-> !push)
		else $error("frame queue overflow");

	// no read from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) qstat.empty |-> !pop)
		else $error("frame queue underflow");

	// every frame holds at least one pair and no more than the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (result.pair_count != '0
			&& result.pair_count <= irpw_pkg::PAIR_W'(MAX_PAIRS)))
		else $error("pair count out of range");

	// key index is a table position or unknown
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> result.key_index <= irpw_pkg::KEY_UNKNOWN)
		else $error("key index out of range");

endmodule
